FILE: sv/dmr_tx_pkg.sv
`timescale 1ns / 1ps
package dmr_tx_pkg;

    localparam int SamplesPerSymbol = 10;
    localparam int TapsPerPhase     = 9;
    localparam int FifoDepth        = 512;
    localparam int FrameBytes       = 33;
    localparam int FillBytes        = 39;
    localparam int FrameSeqBytes    = 72;
    localparam int PreambleMax      = 1200;
    localparam int CoefCount        = 90;
    localparam int LowFreqBytes     = 15;

    localparam logic [7:0] SyncByte   = 8'h5F;
    localparam logic [7:0] LowFreqAlt = 8'h55;
    localparam logic [7:0] LowFreqHi  = 8'hFF;

    localparam logic FuncPush = 1'b0;
    localparam logic FuncSlot = 1'b1;

    localparam logic [1:0] CalNone    = 2'd0;
    localparam logic [1:0] CalDev     = 2'd1;
    localparam logic [1:0] CalLowFreq = 2'd2;
    localparam logic [1:0] CalUnused  = 2'd3;

    localparam logic RegPreamble = 1'b0;
    localparam logic RegCalMode  = 1'b1;

    typedef enum logic [2:0] {
        SEG_IDLE     = 3'd0,
        SEG_PREAMBLE = 3'd1,
        SEG_FRAME    = 3'd2,
        SEG_DEV_CAL  = 3'd3,
        SEG_LF_CAL   = 3'd4
    } t_seg;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_RUN  = 2'd1
    } t_bk_state;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
        logic       transmitter_on;
    } t_in_word;

    typedef struct packed {
        logic        kind;
        logic        accepted;
        logic [15:0] sample;
        logic        last;
    } t_out_word;

    // front-to-back command
    typedef struct packed {
        logic       is_ack;
        logic       accepted;
        logic [7:0] byte_val;
    } t_cmd;

    function automatic logic signed [16:0] coef_at(input int idx);
        logic signed [16:0] c [CoefCount];
        c = '{
            0, 0, 0, 0, 0, 0, 0, 0, 0,
            850, 592, 219, -234, -720, -1179, -1548, -1769, -1795, -1597,
            -1172, -544, 237, 1092, 1927, 2637, 3120, 3286, 3073, 2454,
            1447, 116, -1431, -3043, -4544, -5739, -6442, -6483, -5735, -4121,
            -1633, 1669, 5651, 10118, 14822, 19485, 23811, 27521, 30368, 32157,
            32768,
            32157, 30368, 27521, 23811, 19485, 14822, 10118, 5651, 1669, -1633,
            -4121, -5735, -6483, -6442, -5739, -4544, -3043, -1431, 116, 1447,
            2454, 3073, 3286, 3120, 2637, 1927, 1092, 237, -544, -1172,
            -1597, -1795, -1769, -1548, -1179, -720, -234, 219, 592, 850
        };
        if (idx >= 0 && idx < CoefCount) begin
            return c[idx];
        end
        return 17'sd0;
    endfunction

    function automatic logic [7:0] fill_at(input logic [5:0] idx);
        logic [7:0] f [FillBytes];
        f = '{
            8'h63, 8'hEA, 8'h00, 8'h76, 8'h6C, 8'h76, 8'hC4, 8'h52, 8'hC8, 8'h78,
            8'h09, 8'h2D, 8'hB8, 8'h79, 8'h27, 8'h57, 8'h9B, 8'h31, 8'hBC, 8'h3E,
            8'hEA, 8'h45, 8'hC3, 8'h30, 8'h49, 8'h17, 8'h93, 8'hAE, 8'h8B, 8'h6D,
            8'hA4, 8'hA5, 8'hAD, 8'hA2, 8'hF1, 8'h35, 8'hB5, 8'h3C, 8'h1E
        };
        if (int'(idx) < FillBytes) begin
            return f[idx];
        end
        return 8'h00;
    endfunction

    // level codes: 0 zero, 1 +0.545, 2 +0.182, 3 -0.182, 4 -0.545
    function automatic logic signed [15:0] level_of(input logic [2:0] code);
        case (code)
            3'd1:    return 16'sd17859;
            3'd2:    return 16'sd5964;
            3'd3:    return -16'sd5964;
            3'd4:    return -16'sd17859;
            default: return 16'sd0;
        endcase
    endfunction

    function automatic logic [2:0] dibit_code(input logic [1:0] d);
        case (d)
            2'd3:    return 3'd1;
            2'd2:    return 3'd2;
            2'd0:    return 3'd3;
            default: return 3'd4;
        endcase
    endfunction

endpackage

FILE: sv/dmr_tx_front.sv
`timescale 1ns / 1ps
module dmr_tx_front #(
    parameter int FIFO_DEPTH = dmr_tx_pkg::FifoDepth
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  dmr_tx_pkg::t_in_word  i_word,
    input  logic [10:0]           i_preamble_bytes,
    input  logic [1:0]            i_cal_mode,
    output logic                  o_cmd_valid,
    input  logic                  i_cmd_ready,
    output dmr_tx_pkg::t_cmd      o_cmd
);
    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = AW + 1;

    logic [7:0]    r_mem [FIFO_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_count;
    dmr_tx_pkg::t_seg r_seg;
    logic [10:0]   r_pos;

    // stage 1 holds the accepted word while the store read completes
    logic                 r_s1_valid;
    dmr_tx_pkg::t_in_word r_s1;
    logic                 r_s1_ack_ok;
    logic                 r_s1_none;
    logic [7:0]           r_s1_byte;
    logic                 r_s1_pop;
    logic [7:0]           r_rd;

    logic                  r_q_valid;
    dmr_tx_pkg::t_cmd      r_q;

    logic [10:0] pre_len;
    logic [10:0] seg_len;
    dmr_tx_pkg::t_seg seg_now;
    logic [10:0] pos_now;
    logic        acc;
    logic        s1_free;
    logic        full;
    logic        push_ok;
    logic [7:0]  byte_sel;
    logic        pop_now;
    logic        none_now;
    logic [10:0] pos_inc;

    assign pre_len = (i_preamble_bytes > 11'(dmr_tx_pkg::PreambleMax))
                   ? 11'(dmr_tx_pkg::PreambleMax) : i_preamble_bytes;
    assign full    = (r_count == CW'(FIFO_DEPTH));
    assign s1_free = !r_s1_valid || !r_q_valid || i_cmd_ready;
    assign o_ready = s1_free;
    assign acc     = i_valid && o_ready;
    assign push_ok = !full;

    always_comb begin
        seg_now = r_seg;
        pos_now = r_pos;
        if (r_seg == dmr_tx_pkg::SEG_IDLE) begin
            pos_now = '0;
            if (i_cal_mode == dmr_tx_pkg::CalDev) begin
                seg_now = dmr_tx_pkg::SEG_DEV_CAL;
            end else if (i_cal_mode == dmr_tx_pkg::CalLowFreq) begin
                seg_now = dmr_tx_pkg::SEG_LF_CAL;
            end else if (i_cal_mode == dmr_tx_pkg::CalNone &&
                         r_count >= CW'(dmr_tx_pkg::FrameBytes)) begin
                if (!i_word.transmitter_on) begin
                    if (pre_len != '0) seg_now = dmr_tx_pkg::SEG_PREAMBLE;
                end else begin
                    seg_now = dmr_tx_pkg::SEG_FRAME;
                end
            end
        end
        none_now = (seg_now == dmr_tx_pkg::SEG_IDLE);
        case (seg_now)
            dmr_tx_pkg::SEG_PREAMBLE: seg_len = pre_len;
            dmr_tx_pkg::SEG_FRAME:    seg_len = 11'(dmr_tx_pkg::FrameSeqBytes);
            dmr_tx_pkg::SEG_DEV_CAL:  seg_len = 11'(dmr_tx_pkg::FrameBytes);
            dmr_tx_pkg::SEG_LF_CAL:   seg_len = 11'(dmr_tx_pkg::LowFreqBytes);
            default:                  seg_len = '0;
        endcase
        pop_now = 1'b0;
        case (seg_now)
            dmr_tx_pkg::SEG_FRAME: begin
                if (pos_now < 11'(dmr_tx_pkg::FrameBytes)) begin
                    byte_sel = 8'h00;
                    pop_now  = 1'b1;
                end else begin
                    byte_sel = dmr_tx_pkg::fill_at(6'(pos_now - 11'(dmr_tx_pkg::FrameBytes)));
                end
            end
            dmr_tx_pkg::SEG_LF_CAL: begin
                if (pos_now < 11'd7)       byte_sel = dmr_tx_pkg::LowFreqAlt;
                else if (pos_now == 11'd7) byte_sel = dmr_tx_pkg::SyncByte;
                else                       byte_sel = dmr_tx_pkg::LowFreqHi;
            end
            default: byte_sel = dmr_tx_pkg::SyncByte;
        endcase
        pos_inc = pos_now + 11'd1;
    end

    always_ff @(posedge i_clk) begin
        if (acc && i_word.func == dmr_tx_pkg::FuncPush && push_ok) begin
            r_mem[r_wp] <= i_word.data_byte;
        end
        if (acc) begin
            r_rd        <= r_mem[r_rp];
            r_s1        <= i_word;
            r_s1_ack_ok <= push_ok;
            r_s1_none   <= none_now;
            r_s1_byte   <= byte_sel;
            r_s1_pop    <= pop_now;
        end
        if (s1_free && r_s1_valid) begin
            r_q.is_ack   <= (r_s1.func == dmr_tx_pkg::FuncPush);
            r_q.accepted <= r_s1_ack_ok;
            r_q.byte_val <= r_s1_pop ? r_rd : r_s1_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp       <= '0;
            r_rp       <= '0;
            r_count    <= '0;
            r_seg      <= dmr_tx_pkg::SEG_IDLE;
            r_pos      <= '0;
            r_s1_valid <= 1'b0;
            r_q_valid  <= 1'b0;
        end else begin
            if (acc) begin
                if (i_word.func == dmr_tx_pkg::FuncPush) begin
                    if (push_ok) begin
                        r_wp    <= r_wp + AW'(1);
                        r_count <= r_count + CW'(1);
                    end
                end else if (!none_now) begin
                    if (pop_now && r_count != '0) begin
                        r_rp    <= r_rp + AW'(1);
                        r_count <= r_count - CW'(1);
                    end
                    if (pos_inc >= seg_len) begin
                        r_seg <= dmr_tx_pkg::SEG_IDLE;
                        r_pos <= '0;
                    end else begin
                        r_seg <= seg_now;
                        r_pos <= pos_inc;
                    end
                end
            end
            if (s1_free) begin
                r_s1_valid <= acc;
            end
            if (s1_free && r_s1_valid) begin
                r_q_valid <= !(r_s1.func != dmr_tx_pkg::FuncPush && r_s1_none);
            end else if (i_cmd_ready) begin
                r_q_valid <= 1'b0;
            end
        end
    end

    assign o_cmd_valid = r_q_valid;
    assign o_cmd       = r_q;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(FIFO_DEPTH))
        else $error("fifo count overflow");
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seg == dmr_tx_pkg::SEG_IDLE |-> r_pos == '0)
        else $error("idle with nonzero position");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 |-> r_wp == r_rp)
        else $error("pointers disagree with count");
`endif
endmodule

FILE: sv/dmr_tx_back.sv
`timescale 1ns / 1ps
module dmr_tx_back #(
    parameter int SAMPLES_PER_SYMBOL = dmr_tx_pkg::SamplesPerSymbol,
    parameter int TAPS_PER_PHASE     = dmr_tx_pkg::TapsPerPhase
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    output logic                  o_cmd_ready,
    input  dmr_tx_pkg::t_cmd      i_cmd,
    output logic                  o_valid,
    input  logic                  i_ready,
    output dmr_tx_pkg::t_out_word o_word
);
    localparam int MW = $clog2(SAMPLES_PER_SYMBOL);
    localparam int TW = $clog2(TAPS_PER_PHASE);
    localparam int AccW = 40;

    dmr_tx_pkg::t_bk_state r_state, n_state;
    logic [2:0]    r_hist [TAPS_PER_PHASE];
    logic [7:0]    r_byte;
    logic [1:0]    r_sym;
    logic [MW-1:0] r_m;
    logic [TW-1:0] r_d;
    logic signed [AccW-1:0] r_acc;
    logic signed [32:0]     r_prod;
    logic          r_prod_v;
    logic          r_prod_end;
    logic          r_out_v;
    dmr_tx_pkg::t_out_word r_out;

    logic          pending_ack;
    logic          take;
    logic          out_free;
    logic          mac_go;
    logic          last_tap;
    logic signed [16:0] coef;
    logic signed [15:0] lvl;
    logic signed [AccW-1:0] fin;
    logic signed [AccW-16:0] rnd;
    logic [15:0]   sat;
    logic          last_sample;

    assign out_free    = !r_out_v || i_ready;
    assign pending_ack = i_cmd_valid && i_cmd.is_ack;

    always_comb begin
        n_state = r_state;
        case (r_state)
            dmr_tx_pkg::BK_IDLE:
                if (i_cmd_valid && !i_cmd.is_ack) n_state = dmr_tx_pkg::BK_RUN;
            dmr_tx_pkg::BK_RUN:
                if (r_prod_end && out_free && last_sample) n_state = dmr_tx_pkg::BK_IDLE;
            default: n_state = dmr_tx_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        take        = 1'b0;
        o_cmd_ready = 1'b0;
        if (r_state == dmr_tx_pkg::BK_IDLE && i_cmd_valid) begin
            if (i_cmd.is_ack) begin
                o_cmd_ready = out_free;
            end else begin
                o_cmd_ready = 1'b1;
                take        = 1'b1;
            end
        end
    end

    assign last_tap = (r_d == TW'(TAPS_PER_PHASE - 1));
    // one tap per cycle; stall while the finished sample waits
    assign mac_go   = r_state == dmr_tx_pkg::BK_RUN && !(r_prod_v && r_prod_end && !out_free)
                    && !r_prod_end;
    assign coef = dmr_tx_pkg::coef_at((SAMPLES_PER_SYMBOL - 1 - int'(r_m)) +
                  (TAPS_PER_PHASE - 1 - int'(r_d)) * SAMPLES_PER_SYMBOL);
    assign lvl  = dmr_tx_pkg::level_of(r_hist[r_d]);
    assign fin  = r_acc + AccW'(r_prod);
    assign rnd  = (AccW-15)'((fin + AccW'(16384)) >>> 15);
    assign sat  = (rnd > (AccW-15)'(32767)) ? 16'h7FFF :
                  (rnd < -(AccW-15)'(32768)) ? 16'h8000 : 16'(rnd);
    assign last_sample = (r_sym == 2'd3) && (r_m == MW'(SAMPLES_PER_SYMBOL - 1));

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte <= i_cmd.byte_val;
        end
        if (mac_go) begin
            r_prod <= 33'(coef * lvl);
        end
        if (r_state == dmr_tx_pkg::BK_IDLE && pending_ack && out_free) begin
            r_out.kind     <= 1'b0;
            r_out.accepted <= i_cmd.accepted;
            r_out.sample   <= '0;
            r_out.last     <= 1'b1;
        end else if (r_prod_end && out_free) begin
            r_out.kind     <= 1'b1;
            r_out.accepted <= 1'b0;
            r_out.sample   <= sat;
            r_out.last     <= last_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= dmr_tx_pkg::BK_IDLE;
            r_sym      <= '0;
            r_m        <= '0;
            r_d        <= '0;
            r_acc      <= '0;
            r_prod_v   <= 1'b0;
            r_prod_end <= 1'b0;
            r_out_v    <= 1'b0;
            for (int k = 0; k < TAPS_PER_PHASE; k++) r_hist[k] <= '0;
        end else begin
            r_state <= n_state;
            if (take) begin
                for (int k = TAPS_PER_PHASE - 1; k > 0; k--) r_hist[k] <= r_hist[k-1];
                r_hist[0] <= dmr_tx_pkg::dibit_code(i_cmd.byte_val[7:6]);
                r_sym <= '0;
                r_m   <= '0;
                r_d   <= '0;
                r_acc <= '0;
                r_prod_v   <= 1'b0;
                r_prod_end <= 1'b0;
            end else if (r_state == dmr_tx_pkg::BK_RUN) begin
                if (mac_go) begin
                    if (r_prod_v) r_acc <= r_acc + AccW'(r_prod);
                    r_prod_v   <= 1'b1;
                    r_prod_end <= last_tap;
                    r_d        <= last_tap ? '0 : r_d + TW'(1);
                end else if (r_prod_end && out_free) begin
                    r_acc      <= '0;
                    r_prod_v   <= 1'b0;
                    r_prod_end <= 1'b0;
                    if (r_m == MW'(SAMPLES_PER_SYMBOL - 1)) begin
                        r_m <= '0;
                        if (r_sym != 2'd3) begin
                            r_sym <= r_sym + 2'd1;
                            for (int k = TAPS_PER_PHASE - 1; k > 0; k--)
                                r_hist[k] <= r_hist[k-1];
                            r_hist[0] <= dmr_tx_pkg::dibit_code(
                                2'(r_byte >> (3'd4 - {r_sym, 1'b0})));
                        end
                    end else begin
                        r_m <= r_m + MW'(1);
                    end
                end
            end
            if (r_state == dmr_tx_pkg::BK_IDLE && pending_ack && out_free) begin
                r_out_v <= 1'b1;
            end else if (r_prod_end && out_free) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_word  = r_out;

`ifndef ASSERT_OFF
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_state == dmr_tx_pkg::BK_RUN)
        else $error("byte taken without starting");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && !i_ready |=> r_out_v && $stable(r_out))
        else $error("result lost under stall");
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == dmr_tx_pkg::BK_RUN && n_state == dmr_tx_pkg::BK_IDLE
        |=> r_out_v && r_out.last)
        else $error("byte ended without last flag");
`endif
endmodule

FILE: sv/dmr_direct_mode_tx_modulator_core.sv
`timescale 1ns / 1ps
// Push word: acknowledgement passes stage 1, the command and output registers;
// one word per cycle unless stalled. Slot request: 40 samples at default settings,
// each summed tap by tap on the single multiply-accumulate unit.
// Front accepts the next word while the back part is still filtering.
// Synchronous active-low reset clears pointers, sequence state and symbol history;
// the byte store is not cleared.
module dmr_direct_mode_tx_modulator_core #(
    parameter int SAMPLES_PER_SYMBOL = dmr_tx_pkg::SamplesPerSymbol,
    parameter int TAPS_PER_PHASE     = dmr_tx_pkg::TapsPerPhase,
    parameter int FIFO_DEPTH         = dmr_tx_pkg::FifoDepth
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  dmr_tx_pkg::t_in_word  i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output dmr_tx_pkg::t_out_word o_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    logic [10:0] r_preamble;
    logic [1:0]  r_cal;
    logic        cmd_valid, cmd_ready;
    dmr_tx_pkg::t_cmd cmd;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preamble <= 11'd240;
            r_cal      <= dmr_tx_pkg::CalNone;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == dmr_tx_pkg::RegPreamble) begin
                if (paddr[1:0] == 2'b00) r_preamble <= pwdata[10:0];
            end else if (paddr[1:0] == 2'b00) begin
                r_cal <= pwdata[1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == dmr_tx_pkg::RegCalMode) prdata = {30'd0, r_cal};
        else                                    prdata = {21'd0, r_preamble};
    end

    dmr_tx_front #(.FIFO_DEPTH(FIFO_DEPTH)) u_front (
        .i_clk, .i_rst_n,
        .i_valid, .o_ready, .i_word(i_data),
        .i_preamble_bytes(r_preamble), .i_cal_mode(r_cal),
        .o_cmd_valid(cmd_valid), .i_cmd_ready(cmd_ready), .o_cmd(cmd)
    );

    dmr_tx_back #(
        .SAMPLES_PER_SYMBOL(SAMPLES_PER_SYMBOL),
        .TAPS_PER_PHASE(TAPS_PER_PHASE)
    ) u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(cmd_valid), .o_cmd_ready(cmd_ready), .i_cmd(cmd),
        .o_valid, .i_ready, .o_word(o_data)
    );
endmodule
